// ----- sv/rbfs_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rbfs_pkg
// Shared types, constants and codes for the retry burst fetch scheduler.
// ---------------------------------------------------------------------------
package rbfs_pkg;

    localparam int unsigned SLOTS_DEFAULT = 8;
    localparam logic [3:0]  NONE_SLOT     = 4'd8;
    localparam logic [31:0] CHAIN_RESET   = 32'd1200;
    localparam logic [31:0] CHAIN_STEP    = 32'd400;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [1:0] CFG_BUDGET     = 2'd1;
    localparam logic [1:0] CFG_BACKOFF_LIM = 2'd2;
    localparam logic [1:0] CFG_BACKOFF_ERR = 2'd3;

    // Command codes.
    localparam logic [2:0] CMD_SELECT   = 3'd0;
    localparam logic [2:0] CMD_COMPLETE = 3'd1;
    localparam logic [2:0] CMD_BURST    = 3'd2;
    localparam logic [2:0] CMD_FOCUS    = 3'd3;
    localparam logic [2:0] CMD_ACTIVE   = 3'd4;

    // Outcome codes.
    localparam logic [1:0] OUT_SUCCESS = 2'd0;
    localparam logic [1:0] OUT_LIMITED = 2'd1;
    localparam logic [1:0] OUT_ERROR   = 2'd2;

    // Load states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_FETCHING = 3'd1;
    localparam logic [2:0] ST_READY    = 3'd2;
    localparam logic [2:0] ST_LIMITED  = 3'd3;
    localparam logic [2:0] ST_ERROR    = 3'd4;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EVAL,
        CTL_APPLY,
        CTL_OUT
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic evaluate;
        logic apply;
    } dp_cmd_t;

    typedef struct packed {
        logic result_taken;
    } dp_status_t;

    typedef struct packed {
        logic [2:0] command;
        logic [31:0] now_ms;
        logic [1:0] outcome;
        logic active_flag;
    } req_t;

    typedef struct packed {
        logic [3:0] target_slot;
        logic from_burst;
        logic [31:0] chain_delay_ms;
        logic [2:0] target_state;
        logic flush_cache;
        logic [7:0] pending_bits;
        logic [2:0] focus_slot;
    } rsp_t;

endpackage
`default_nettype wire

// ----- sv/rbfs_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rbfs_req_if / rbfs_rsp_if
// Valid/ready channels for scheduler requests and results.
// ---------------------------------------------------------------------------
interface rbfs_req_if;
    logic valid;
    logic ready;
    rbfs_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rbfs_rsp_if;
    logic valid;
    logic ready;
    rbfs_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/rbfs_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rbfs_ctrl
// Sequencer: capture, evaluate, apply, then present the result.
// ---------------------------------------------------------------------------
module rbfs_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rbfs_pkg::dp_cmd_t         cmd,
    output rbfs_pkg::dp_status_t      status
);

    rbfs_pkg::ctl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbfs_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbfs_pkg::CTL_IDLE:  if (in_valid) state_next = rbfs_pkg::CTL_EVAL;
            rbfs_pkg::CTL_EVAL:  state_next = rbfs_pkg::CTL_APPLY;
            rbfs_pkg::CTL_APPLY: state_next = rbfs_pkg::CTL_OUT;
            rbfs_pkg::CTL_OUT:
            begin
                if (out_ready) state_next = rbfs_pkg::CTL_IDLE;
            end
            default: state_next = rbfs_pkg::CTL_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready = 1'b0;
        out_valid = 1'b0;
        cmd = '0;
        status = '0;
        case (state_reg)
            rbfs_pkg::CTL_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
            end
            rbfs_pkg::CTL_EVAL:  cmd.evaluate = 1'b1;
            rbfs_pkg::CTL_APPLY: cmd.apply = 1'b1;
            rbfs_pkg::CTL_OUT:
            begin
                out_valid = 1'b1;
                status.result_taken = out_ready;
            end
            default: ;
        endcase
    end

    // The result is shown only after a transaction was taken in.
    a_out_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.apply))
        else $error("result raised without apply");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result held");
    a_eval_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evaluate |=> cmd.apply)
        else $error("evaluate not followed by apply");

endmodule
`default_nettype wire

// ----- sv/rbfs_datapath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rbfs_datapath
// Slot bookkeeping, selection, minimum wait search and completion update.
// ---------------------------------------------------------------------------
module rbfs_datapath
#(
    parameter int unsigned SLOTS = rbfs_pkg::SLOTS_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire rbfs_pkg::req_t    req,
    input  wire rbfs_pkg::dp_cmd_t cmd,
    output rbfs_pkg::rsp_t         rsp
);

    // Configuration.
    logic [3:0]  slot_count_reg;
    logic [1:0]  budget_reg;
    logic [15:0] bo_lim_reg, bo_err_reg;

    // State.
    logic [7:0]  pend_reg, pend_next;
    logic [1:0]  rcnt_reg [SLOTS];
    logic [31:0] rtime_reg [SLOTS];
    logic [2:0]  lstate_reg [SLOTS];
    logic [3:0]  prio_reg, prio_next;
    logic [2:0]  focus_reg, focus_next;
    logic [2:0]  rr_reg, rr_next;
    logic        active_reg, active_next;
    logic        dirty_reg, dirty_next;
    logic [3:0]  infl_reg, infl_next;
    logic [1:0]  iflags_reg, iflags_next;
    logic [31:0] chain_reg, chain_next;

    // Captured request and evaluation results.
    rbfs_pkg::req_t req_reg;
    logic [SLOTS-1:0] ready_reg;
    logic [31:0] mind_reg;
    logic        anyrdy_reg;
    rbfs_pkg::rsp_t rsp_reg;

    logic [3:0] n;
    assign n = (slot_count_reg > 4'(SLOTS)) ? 4'(SLOTS) : slot_count_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= 4'd0;
            budget_reg <= 2'd2;
            bo_lim_reg <= 16'd8000;
            bo_err_reg <= 16'd2500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbfs_pkg::CFG_SLOT_COUNT:  slot_count_reg <= cfg_data[3:0];
                rbfs_pkg::CFG_BUDGET:      budget_reg <= cfg_data[1:0];
                rbfs_pkg::CFG_BACKOFF_LIM: bo_lim_reg <= cfg_data;
                rbfs_pkg::CFG_BACKOFF_ERR: bo_err_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Evaluate stage: readiness and smallest remaining wait among pending slots.
    logic [SLOTS-1:0] rdy_c;
    logic [31:0] mind_c, d_c;
    logic        anyrdy_c;
    always_comb
    begin
        mind_c = '0;
        anyrdy_c = 1'b0;
        d_c = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rdy_c[i] = (rtime_reg[i] == 32'd0) || (rtime_reg[i] <= req_reg.now_ms);
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            d_c = rtime_reg[i] - req_reg.now_ms;
            if (4'(i) < n && pend_reg[i])
            begin
                if (rdy_c[i]) anyrdy_c = 1'b1;
                else if (mind_c == 32'd0 || d_c < mind_c) mind_c = d_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture) req_reg <= req;
        if (cmd.evaluate)
        begin
            ready_reg <= rdy_c;
            mind_reg <= mind_c;
            anyrdy_reg <= anyrdy_c;
        end
    end

    // Next position (cur + 1) modulo cnt, for cnt from one to eight, by a short
    // restoring compare and subtract. The position may lie beyond cnt when the
    // slot count was lowered.
    function automatic logic [2:0] wrap_next(input logic [2:0] cur, input logic [3:0] cnt);
        logic [6:0] rem;
        rem = {4'd0, cur} + 7'd1;
        for (int k = 3; k >= 0; k--)
        begin
            if (rem >= ({3'd0, cnt} << k)) rem = rem - ({3'd0, cnt} << k);
        end
        return rem[2:0];
    endfunction

    // Apply stage: one command against the state.
    logic [3:0]  tgt;
    logic        fb, flush, wasact, wrapped, do_fetch, fbit, act;
    logic        prio_rdy, upd_slot, clr_books, lim, ifb, iwas;
    logic [2:0]  newst, ti, pi;
    logic [1:0]  newcnt;
    logic [31:0] newtime, best;
    logic        set_time, set_cnt, set_st;
    logic [7:0]  one;
    always_comb
    begin
        pend_next = pend_reg;
        prio_next = prio_reg;
        focus_next = focus_reg;
        rr_next = rr_reg;
        active_next = active_reg;
        dirty_next = dirty_reg;
        infl_next = infl_reg;
        iflags_next = iflags_reg;
        chain_next = chain_reg;
        tgt = rbfs_pkg::NONE_SLOT;
        fb = 1'b0;
        flush = 1'b0;
        wrapped = 1'b0;
        do_fetch = 1'b0;
        clr_books = 1'b0;
        upd_slot = 1'b0;
        set_time = 1'b0;
        set_cnt = 1'b0;
        set_st = 1'b0;
        newst = rbfs_pkg::ST_IDLE;
        newcnt = 2'd0;
        newtime = 32'd0;
        best = 32'd0;
        wasact = pend_reg != 8'd0;
        pi = prio_reg[2:0];
        prio_rdy = (prio_reg < n) && ready_reg[pi];
        fbit = 1'b0;
        act = 1'b0;
        lim = 1'b0;
        ifb = iflags_reg[0];
        iwas = iflags_reg[1];
        ti = infl_reg[2:0];
        one = 8'd1 << ti;
        case (req_reg.command)
            rbfs_pkg::CMD_SELECT:
            begin
                if (active_reg && n != 4'd0)
                begin
                    act = 1'b1;
                    if (prio_rdy)
                    begin
                        tgt = prio_reg;
                        prio_next = rbfs_pkg::NONE_SLOT;
                        fbit = wasact && pend_reg[pi];
                    end
                    else if (wasact)
                    begin
                        fbit = 1'b1;
                        if (pend_reg[focus_reg] && ready_reg[focus_reg]
                            && {1'b0, focus_reg} < n)
                        begin
                            tgt = {1'b0, focus_reg};
                        end
                        else
                        begin
                            for (int i = SLOTS - 1; i >= 0; i--)
                            begin
                                if (pend_reg[i] && ready_reg[i]) tgt = 4'(i);
                            end
                        end
                    end
                    else
                    begin
                        tgt = (rr_reg >= n[2:0] && n != 4'd8) ? 4'd0 : {1'b0, rr_reg};
                        rr_next = tgt[2:0];
                        upd_slot = 1'b1;
                        set_cnt = 1'b1;
                        newcnt = 2'd0;
                    end
                end
                if (act && tgt == rbfs_pkg::NONE_SLOT)
                begin
                    // Nothing ready: report the shortest wait.
                    if (!anyrdy_reg)
                    begin
                        best = mind_reg;
                        if (best == 32'd0 && prio_reg < n && !ready_reg[pi])
                        begin
                            best = rtime_reg[pi] - req_reg.now_ms;
                        end
                    end
                    if (best != 32'd0) chain_next = best;
                end
                else if (act && tgt < n)
                begin
                    do_fetch = 1'b1;
                    fb = fbit;
                    infl_next = tgt;
                    iflags_next = {wasact, fbit};
                    upd_slot = 1'b1;
                    set_st = 1'b1;
                    newst = rbfs_pkg::ST_FETCHING;
                end
                if (!do_fetch) tgt = rbfs_pkg::NONE_SLOT;
            end
            rbfs_pkg::CMD_COMPLETE:
            begin
                if (infl_reg < 4'd8)
                begin
                    tgt = infl_reg;
                    fb = ifb;
                    upd_slot = 1'b1;
                    set_st = 1'b1;
                    if (req_reg.outcome == rbfs_pkg::OUT_SUCCESS)
                    begin
                        set_cnt = 1'b1;
                        set_time = 1'b1;
                        pend_next = pend_reg & ~one;
                        newst = rbfs_pkg::ST_READY;
                        chain_next = rbfs_pkg::CHAIN_STEP;
                        dirty_next = 1'b1;
                    end
                    else
                    begin
                        lim = req_reg.outcome == rbfs_pkg::OUT_LIMITED;
                        newst = lim ? rbfs_pkg::ST_LIMITED : rbfs_pkg::ST_ERROR;
                        if (ifb && rcnt_reg[ti] < budget_reg)
                        begin
                            set_cnt = 1'b1;
                            newcnt = rcnt_reg[ti] + 2'd1;
                            pend_next = pend_reg | one;
                            set_time = 1'b1;
                            newtime = req_reg.now_ms
                                + {16'd0, lim ? bo_lim_reg : bo_err_reg};
                            chain_next = rbfs_pkg::CHAIN_STEP;
                        end
                        else if (ifb)
                        begin
                            pend_next = pend_reg & ~one;
                            chain_next = rbfs_pkg::CHAIN_STEP;
                        end
                    end
                    if (!ifb && ti == rr_reg)
                    begin
                        if (n == 4'd0) rr_next = 3'd0;
                        else rr_next = wrap_next(rr_reg, n);
                        wrapped = rr_next == 3'd0;
                    end
                    if (dirty_next && (wrapped || (iwas && pend_next == 8'd0)))
                    begin
                        dirty_next = 1'b0;
                        flush = 1'b1;
                    end
                    infl_next = rbfs_pkg::NONE_SLOT;
                    iflags_next = 2'd0;
                end
            end
            rbfs_pkg::CMD_BURST:
            begin
                if (active_reg && n != 4'd0)
                begin
                    pend_next = 8'((9'd1 << n) - 9'd1);
                    prio_next = rbfs_pkg::NONE_SLOT;
                    clr_books = 1'b1;
                end
            end
            rbfs_pkg::CMD_FOCUS:
            begin
                if (n > 4'd1)
                begin
                    focus_next = wrap_next(focus_reg, n);
                    prio_next = {1'b0, focus_next};
                end
            end
            rbfs_pkg::CMD_ACTIVE:
            begin
                active_next = req_reg.active_flag;
                if (!req_reg.active_flag)
                begin
                    pend_next = 8'd0;
                    prio_next = rbfs_pkg::NONE_SLOT;
                    clr_books = 1'b1;
                    chain_next = rbfs_pkg::CHAIN_RESET;
                end
            end
            default: ;
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            prio_reg <= rbfs_pkg::NONE_SLOT;
            focus_reg <= '0;
            rr_reg <= '0;
            active_reg <= 1'b0;
            dirty_reg <= 1'b0;
            infl_reg <= rbfs_pkg::NONE_SLOT;
            iflags_reg <= '0;
            chain_reg <= rbfs_pkg::CHAIN_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                rcnt_reg[i] <= '0;
                rtime_reg[i] <= '0;
                lstate_reg[i] <= rbfs_pkg::ST_IDLE;
            end
        end
        else if (cmd.apply)
        begin
            pend_reg <= pend_next;
            prio_reg <= prio_next;
            focus_reg <= focus_next;
            rr_reg <= rr_next;
            active_reg <= active_next;
            dirty_reg <= dirty_next;
            infl_reg <= infl_next;
            iflags_reg <= iflags_next;
            chain_reg <= chain_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (clr_books)
                begin
                    rcnt_reg[i] <= '0;
                    rtime_reg[i] <= '0;
                end
                else if (upd_slot && tgt == 4'(i))
                begin
                    if (set_cnt) rcnt_reg[i] <= newcnt;
                    if (set_time) rtime_reg[i] <= newtime;
                end
                if (upd_slot && set_st && tgt == 4'(i)) lstate_reg[i] <= newst;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            rsp_reg.target_slot <= tgt;
            rsp_reg.from_burst <= (tgt < 4'd8) ? fb : 1'b0;
            rsp_reg.chain_delay_ms <= chain_next;
            rsp_reg.target_state <= (tgt < 4'd8) ? newst : rbfs_pkg::ST_IDLE;
            rsp_reg.flush_cache <= flush;
            rsp_reg.pending_bits <= pend_next;
            rsp_reg.focus_slot <= focus_next;
        end
    end
    assign rsp = rsp_reg;

    a_infl_range: assert property (@(posedge clk) disable iff (!rst_n)
        infl_reg <= rbfs_pkg::NONE_SLOT)
        else $error("in-flight slot out of range");
    a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        infl_reg == rbfs_pkg::NONE_SLOT |-> iflags_reg == 2'd0)
        else $error("flags set with nothing in flight");
    a_flush_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply && flush |=> !dirty_reg)
        else $error("flush left cache dirty");

endmodule
`default_nettype wire

// ----- sv/retry_burst_fetch_scheduler.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// retry_burst_fetch_scheduler
// Slot scheduler with burst, priority, round-robin and retry bookkeeping.
// ---------------------------------------------------------------------------
// Channel   Role    Payload
// req       sink    command, now_ms, outcome, active_flag
// rsp       source  target_slot, from_burst, chain_delay_ms, target_state,
//                   flush_cache, pending_bits, focus_slot
// cfg       write   cfg_we, cfg_index, cfg_data
//
// The request is captured at the accepting edge; the readiness compare and
// minimum-wait search are registered, then the command is applied and the
// result is registered and shown. A new transaction is taken the cycle after its
// result is accepted, so no new transaction is taken while one is in flight.
// A stalled result holds and blocks new input. Reset is asynchronous.
// ---------------------------------------------------------------------------
module retry_burst_fetch_scheduler
#(
    parameter int unsigned SLOTS = rbfs_pkg::SLOTS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    rbfs_req_if.sink         req,
    rbfs_rsp_if.source       rsp,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    rbfs_pkg::dp_cmd_t    cmd;
    rbfs_pkg::dp_status_t status;

    // Sequencer.
    rbfs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath.
    rbfs_datapath #(.SLOTS(SLOTS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.data),
        .cmd       (cmd),
        .rsp       (rsp.data)
    );

    a_taken_valid: assert property (@(posedge clk) disable iff (!rst_n)
        status.result_taken |-> rsp.valid)
        else $error("result taken while not valid");

endmodule
`default_nettype wire
